[src/msde_pkg.sv]
package msde_pkg;

    localparam int LG_FRAC = 28;
    localparam int LG_W    = 40;

    // log2 values, 28 fraction bits
    typedef logic signed [LG_W-1:0] lg_t;

    typedef struct packed {
        logic [5:0]  e;
        logic [31:0] m;
    } norm_t;

    localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
    // ceil(2^42 / 10): exact truncating divide by ten below 2^39
    localparam logic [38:0] DIV10_M   = 39'd439804651111;
    localparam int          DIV10_SH  = 42;
    localparam logic [61:0] EX2_CAP   = {1'b1, 61'b0};

    function automatic longint unsigned c_isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        r = 0;
        x = v;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] c_root(int k);
        longint unsigned r;
        r = 64'd1 << 31;
        for (int i = 1; i <= k; i++) r = c_isqrt(r << 30);
        return r[31:0];
    endfunction

    function automatic longint c_lg2(longint unsigned x);
        int              e;
        longint unsigned m;
        longint          fr;
        e  = 0;
        fr = 0;
        for (int i = 0; i < 64; i++) if (x[i]) e = i;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        for (int i = 1; i <= LG_FRAC; i++) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m  = m >> 1;
                fr = fr | (64'sd1 << (LG_FRAC - i));
            end
        end
        return longint'(e) * (64'sd1 << LG_FRAC) + fr;
    endfunction

    function automatic lg_t c_lgc(longint unsigned x);
        return lg_t'(c_lg2(x) - c_lg2(10000));
    endfunction

    function automatic logic [31:0] c_fix30(longint unsigned x);
        longint unsigned v;
        v = (x * (64'd1 << 30) + 64'd5000) / 64'd10000;
        return v[31:0];
    endfunction

    localparam lg_t AC_LGCOEF [4] = '{c_lgc(100), c_lgc(120), c_lgc(80), c_lgc(200)};
    localparam lg_t AC_LGCUT  [4] = '{c_lgc(400), c_lgc(350), c_lgc(1500), c_lgc(800)};
    localparam logic [4:0] AC_Q [4] = '{5'd15, 5'd15, 5'd12, 5'd18};
    localparam lg_t FL_LGCOEF [4] = '{c_lgc(50), c_lgc(80), c_lgc(150), c_lgc(30)};
    localparam lg_t FL_LGCUT  [4] = '{c_lgc(200), c_lgc(180), c_lgc(250), c_lgc(600)};
    localparam logic [2:0] FL_POW [4] = '{3'd3, 3'd4, 3'd2, 3'd6};
    localparam logic [31:0] PK_POS [2] = '{c_fix30(480), c_fix30(320)};
    localparam logic [31:0] PK_G   [2] = '{c_fix30(10), c_fix30(8)};
    localparam lg_t PK_LGNUM [2] = '{lg_t'(c_lg2(8000) - 3 * c_lg2(10000)),
                                     lg_t'(c_lg2(14400) - 3 * c_lg2(10000))};

    function automatic norm_t norm64(logic [63:0] x);
        norm_t r;
        r.e = '0;
        for (int i = 0; i < 64; i++) if (x[i]) r.e = 6'(i);
        if (r.e >= 6'd31) r.m = 32'(x >> (r.e - 6'd31));
        else              r.m = 32'(x << (6'd31 - r.e));
        return r;
    endfunction

    // one squaring step of the log: bit in [32], mantissa in [31:0]
    function automatic logic [32:0] sq_step(logic [31:0] m);
        logic [63:0] p;
        p = {32'b0, m} * {32'b0, m};
        if (p[63]) return {1'b1, p[63:32]};
        return {1'b0, p[62:31]};
    endfunction

    function automatic logic [31:0] ex2_mul(logic [31:0] m, logic [31:0] r);
        logic [63:0] p;
        p = {32'b0, m} * {32'b0, r};
        return p[61:30];
    endfunction

    function automatic logic [61:0] ex2_shift(logic [31:0] m, logic signed [11:0] n, int p);
        int s;
        s = p - 30 + int'(n);
        if (s > 30)  return EX2_CAP;
        if (s >= 0)  return 62'(m) << s;
        if (s < -62) return '0;
        return 62'(m) >> (-s);
    endfunction

    function automatic lg_t div10_fin(logic neg, logic [58:0] phi, logic [57:0] plo);
        logic [77:0] acc;
        logic [35:0] q;
        acc = {phi, 19'b0} + 78'(plo);
        q   = acc[77:DIV10_SH];
        return neg ? -lg_t'(q) : lg_t'(q);
    endfunction

endpackage

[src/material_spectral_density_eval_top.sv]
// Throughput: one word per cycle; the whole pipeline advances together and
// freezes while a result waits on m_tready.
// Each log2 and exp2 takes 28 stages, one 32x32 multiply per lane per stage.
// Reset (aresetn low, synchronous) empties the pipeline and selects material 0.
module material_spectral_density_eval_top #(
    parameter int FREQ_FRAC_BITS = 22,
    parameter int OUT_FRAC_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] freq_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] density_value
);
    import msde_pkg::*;

    localparam int  LAT    = 99;
    localparam int  STEPS  = LG_FRAC;
    localparam lg_t LW_OFS = lg_t'(longint'(FREQ_FRAC_BITS) <<< LG_FRAC);
    localparam lg_t U_MAX  = lg_t'(64'sd6 <<< LG_FRAC);

    typedef struct packed {
        logic [5:0]  e;
        logic [31:0] m;
        logic [27:0] fr;
    } lgl_t;

    typedef struct packed {
        logic signed [11:0] n;
        logic [27:0]        f;
        logic [31:0]        m;
    } x2l_t;

    typedef struct packed {
        logic        pos;
        norm_t       wn;
        logic [2:0]  k;
        logic [30:0] dk;
        logic [30:0] gk;
    } p1_t;

    typedef struct packed {
        logic        pos;
        norm_t       wn;
        logic [2:0]  k;
        logic [61:0] dsq;
        logic [61:0] gsq;
    } p2_t;

    typedef struct packed {
        logic        pos;
        norm_t       wn;
        logic [2:0]  k;
        logic [62:0] den;
    } p3_t;

    typedef struct packed {
        logic       pos;
        logic [2:0] k;
        lgl_t       wl;
        lgl_t       dl;
    } lgs_t;

    typedef struct packed {
        logic pos;
        lg_t  lw;
        lg_t  tpk;
        lg_t  x_ac;
        lg_t  ul_fl;
        lg_t  x_fl;
    } a_t;

    typedef struct packed {
        logic        pos;
        lg_t         lw;
        lg_t         tpk;
        lg_t         ul_fl;
        logic        n_ac;
        logic [58:0] ph_ac;
        logic [57:0] pl_ac;
        logic        n_fl;
        logic [58:0] ph_fl;
        logic [57:0] pl_fl;
    } d1_t;

    typedef struct packed {
        logic pos;
        lg_t  lw;
        lg_t  tpk;
        lg_t  ul_ac;
        lg_t  ul_fl;
        lg_t  lwp_fl;
    } b_t;

    typedef struct packed {
        logic pos;
        logic z_ac;
        logic z_fl;
        lg_t  lw;
        lg_t  tpk;
        lg_t  lwp_fl;
        x2l_t ac;
        x2l_t fl;
    } e1_t;

    typedef struct packed {
        logic        pos;
        logic        z_ac;
        logic        z_fl;
        lg_t         lw;
        lg_t         tpk;
        lg_t         lwp_fl;
        logic [35:0] u_ac;
        logic [35:0] u_fl;
    } c_t;

    typedef struct packed {
        logic        pos;
        logic        z_ac;
        logic        z_fl;
        lg_t         lw;
        lg_t         tpk;
        lg_t         lwp_fl;
        logic [36:0] y_ac;
        logic [36:0] y_fl;
    } y_t;

    typedef struct packed {
        logic pos;
        logic z_ac;
        logic z_fl;
        lg_t  lt_ac;
        lg_t  lt_fl;
        lg_t  tpk;
    } t_t;

    typedef struct packed {
        logic pos;
        logic z_ac;
        logic z_fl;
        x2l_t ac;
        x2l_t fl;
        x2l_t pk;
    } e2_t;

    typedef struct packed {
        logic [61:0] ac;
        logic [61:0] fl;
        logic [61:0] pk;
    } r_t;

    logic [1:0]            ms_reg;
    logic [LAT-1:0]        vld_reg, vld_next;
    logic signed [23:0]    w_reg;
    p1_t                   p1_reg, p1_next;
    p2_t                   p2_reg, p2_next;
    p3_t                   p3_reg, p3_next;
    lgs_t                  lg_reg [0:STEPS];
    lgs_t                  lg_next [0:STEPS];
    a_t                    a_reg, a_next;
    d1_t                   d1_reg, d1_next;
    b_t                    b_reg, b_next;
    e1_t                   e1_reg [0:STEPS];
    e1_t                   e1_next [0:STEPS];
    c_t                    c_reg, c_next;
    y_t                    y_reg, y_next;
    t_t                    t_reg, t_next;
    e2_t                   e2_reg [0:STEPS];
    e2_t                   e2_next [0:STEPS];
    r_t                    r_reg, r_next;
    logic [31:0]           out_reg, out_next;
    logic                  pipe_en;

    function automatic x2l_t x2_init(lg_t l);
        x2l_t r;
        r.n = l[LG_W-1:LG_FRAC];
        r.f = l[LG_FRAC-1:0];
        r.m = 32'd1 << 30;
        return r;
    endfunction

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {30'd0, ms_reg};
    assign pipe_en  = !vld_reg[LAT-1] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            ms_reg <= pwdata[1:0];
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // front end: normalize w, form the peak distance and its scale shift
    always_comb begin
        lg_t         w30;
        lg_t         dd;
        logic [38:0] d;
        logic [2:0]  k;
        w30 = lg_t'(w_reg) <<< (30 - FREQ_FRAC_BITS);
        dd  = w30 - lg_t'(PK_POS[ms_reg[0]]);
        d   = dd[LG_W-1] ? 39'(-dd) : 39'(dd);
        k   = '0;
        for (int i = 1; i < 8; i++) begin
            if ((d >> (i - 1)) >= 39'(64'd1 << 31)) k = 3'(i);
        end
        p1_next.pos = (w_reg > 24'sd0);
        p1_next.wn  = norm64({40'd0, w_reg});
        p1_next.k   = k;
        p1_next.dk  = 31'(d >> k);
        p1_next.gk  = 31'(PK_G[ms_reg[0]] >> k);
    end

    always_comb begin
        p2_next.pos = p1_reg.pos;
        p2_next.wn  = p1_reg.wn;
        p2_next.k   = p1_reg.k;
        p2_next.dsq = {31'd0, p1_reg.dk} * {31'd0, p1_reg.dk};
        p2_next.gsq = {31'd0, p1_reg.gk} * {31'd0, p1_reg.gk};
    end

    always_comb begin
        p3_next.pos = p2_reg.pos;
        p3_next.wn  = p2_reg.wn;
        p3_next.k   = p2_reg.k;
        p3_next.den = 63'(p2_reg.dsq) + 63'(p2_reg.gsq);
    end

    always_comb begin
        norm_t dn;
        dn              = norm64({1'b0, p3_reg.den});
        lg_next[0].pos  = p3_reg.pos;
        lg_next[0].k    = p3_reg.k;
        lg_next[0].wl   = '{e: p3_reg.wn.e, m: p3_reg.wn.m, fr: '0};
        lg_next[0].dl   = '{e: dn.e, m: dn.m, fr: '0};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            w_reg     <= s_tdata;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
            lg_reg[0] <= lg_next[0];
        end
    end

    // log2 by repeated squaring: one fraction bit per stage, both lanes
    for (genvar j = 1; j <= STEPS; j++) begin : g_lg
        always_comb begin
            logic [32:0] sw;
            logic [32:0] sd;
            sw                       = sq_step(lg_reg[j-1].wl.m);
            sd                       = sq_step(lg_reg[j-1].dl.m);
            lg_next[j]               = lg_reg[j-1];
            lg_next[j].wl.m          = sw[31:0];
            lg_next[j].wl.fr[STEPS-j] = sw[32];
            lg_next[j].dl.m          = sd[31:0];
            lg_next[j].dl.fr[STEPS-j] = sd[32];
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) lg_reg[j] <= lg_next[j];
        end
    end

    always_comb begin
        lgs_t l;
        lg_t  lw;
        lg_t  lden;
        lg_t  kofs;
        lg_t  dac;
        l            = lg_reg[STEPS];
        lw           = lg_t'({l.wl.e, l.wl.fr}) - LW_OFS;
        kofs         = (lg_t'({l.k, 1'b0}) - lg_t'(60)) <<< LG_FRAC;
        lden         = lg_t'({l.dl.e, l.dl.fr}) + kofs;
        dac          = lw - AC_LGCUT[ms_reg];
        a_next.pos   = l.pos;
        a_next.lw    = lw;
        a_next.tpk   = PK_LGNUM[ms_reg[0]] - lden;
        a_next.x_ac  = lg_t'(dac * lg_t'(AC_Q[ms_reg]));
        a_next.ul_fl = (lw - FL_LGCUT[ms_reg]) <<< 1;
        a_next.x_fl  = lg_t'(lw * lg_t'(FL_POW[ms_reg]));
    end

    // divide by ten: reciprocal multiply split in two halves
    always_comb begin
        logic [38:0] mac;
        logic [38:0] mfl;
        mac            = a_reg.x_ac[LG_W-1] ? 39'(-a_reg.x_ac) : 39'(a_reg.x_ac);
        mfl            = a_reg.x_fl[LG_W-1] ? 39'(-a_reg.x_fl) : 39'(a_reg.x_fl);
        d1_next.pos    = a_reg.pos;
        d1_next.lw     = a_reg.lw;
        d1_next.tpk    = a_reg.tpk;
        d1_next.ul_fl  = a_reg.ul_fl;
        d1_next.n_ac   = a_reg.x_ac[LG_W-1];
        d1_next.ph_ac  = 59'(mac[38:19]) * 59'(DIV10_M);
        d1_next.pl_ac  = 58'(mac[18:0]) * 58'(DIV10_M);
        d1_next.n_fl   = a_reg.x_fl[LG_W-1];
        d1_next.ph_fl  = 59'(mfl[38:19]) * 59'(DIV10_M);
        d1_next.pl_fl  = 58'(mfl[18:0]) * 58'(DIV10_M);
    end

    always_comb begin
        b_next.pos    = d1_reg.pos;
        b_next.lw     = d1_reg.lw;
        b_next.tpk    = d1_reg.tpk;
        b_next.ul_fl  = d1_reg.ul_fl;
        b_next.ul_ac  = div10_fin(d1_reg.n_ac, d1_reg.ph_ac, d1_reg.pl_ac);
        b_next.lwp_fl = div10_fin(d1_reg.n_fl, d1_reg.ph_fl, d1_reg.pl_fl);
    end

    always_comb begin
        e1_next[0].pos    = b_reg.pos;
        e1_next[0].z_ac   = (b_reg.ul_ac >= U_MAX);
        e1_next[0].z_fl   = (b_reg.ul_fl >= U_MAX);
        e1_next[0].lw     = b_reg.lw;
        e1_next[0].tpk    = b_reg.tpk;
        e1_next[0].lwp_fl = b_reg.lwp_fl;
        e1_next[0].ac     = x2_init(b_reg.ul_ac);
        e1_next[0].fl     = x2_init(b_reg.ul_fl);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_reg     <= a_next;
            d1_reg    <= d1_next;
            b_reg     <= b_next;
            e1_reg[0] <= e1_next[0];
        end
    end

    // first exp2: one root multiply per fraction bit
    for (genvar j = 1; j <= STEPS; j++) begin : g_x1
        localparam logic [31:0] RT = c_root(j);

        always_comb begin
            e1_next[j] = e1_reg[j-1];
            if (e1_reg[j-1].ac.f[STEPS-j]) e1_next[j].ac.m = ex2_mul(e1_reg[j-1].ac.m, RT);
            if (e1_reg[j-1].fl.f[STEPS-j]) e1_next[j].fl.m = ex2_mul(e1_reg[j-1].fl.m, RT);
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) e1_reg[j] <= e1_next[j];
        end
    end

    always_comb begin
        e1_t  e;
        logic [61:0] ua;
        logic [61:0] uf;
        e             = e1_reg[STEPS];
        ua            = ex2_shift(e.ac.m, e.ac.n, LG_FRAC);
        uf            = ex2_shift(e.fl.m, e.fl.n, LG_FRAC);
        c_next.pos    = e.pos;
        c_next.z_ac   = e.z_ac;
        c_next.z_fl   = e.z_fl;
        c_next.lw     = e.lw;
        c_next.tpk    = e.tpk;
        c_next.lwp_fl = e.lwp_fl;
        c_next.u_ac   = ua[35:0];
        c_next.u_fl   = uf[35:0];
    end

    always_comb begin
        logic [64:0] pa;
        logic [64:0] pf;
        pa            = 65'(c_reg.u_ac) * 65'(LOG2E_Q28);
        pf            = 65'(c_reg.u_fl) * 65'(LOG2E_Q28);
        y_next.pos    = c_reg.pos;
        y_next.z_ac   = c_reg.z_ac;
        y_next.z_fl   = c_reg.z_fl;
        y_next.lw     = c_reg.lw;
        y_next.tpk    = c_reg.tpk;
        y_next.lwp_fl = c_reg.lwp_fl;
        y_next.y_ac   = pa[LG_FRAC+36:LG_FRAC];
        y_next.y_fl   = pf[LG_FRAC+36:LG_FRAC];
    end

    always_comb begin
        t_next.pos   = y_reg.pos;
        t_next.z_ac  = y_reg.z_ac;
        t_next.z_fl  = y_reg.z_fl;
        t_next.tpk   = y_reg.tpk;
        t_next.lt_ac = AC_LGCOEF[ms_reg] + y_reg.lw - lg_t'(y_reg.y_ac);
        t_next.lt_fl = FL_LGCOEF[ms_reg] + y_reg.lwp_fl - lg_t'(y_reg.y_fl);
    end

    always_comb begin
        e2_next[0].pos  = t_reg.pos;
        e2_next[0].z_ac = t_reg.z_ac;
        e2_next[0].z_fl = t_reg.z_fl;
        e2_next[0].ac   = x2_init(t_reg.lt_ac);
        e2_next[0].fl   = x2_init(t_reg.lt_fl);
        e2_next[0].pk   = x2_init(t_reg.tpk);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_reg     <= c_next;
            y_reg     <= y_next;
            t_reg     <= t_next;
            e2_reg[0] <= e2_next[0];
        end
    end

    // second exp2: acoustic, flexural and peak lanes side by side
    for (genvar j = 1; j <= STEPS; j++) begin : g_x2
        localparam logic [31:0] RT = c_root(j);

        always_comb begin
            e2_next[j] = e2_reg[j-1];
            if (e2_reg[j-1].ac.f[STEPS-j]) e2_next[j].ac.m = ex2_mul(e2_reg[j-1].ac.m, RT);
            if (e2_reg[j-1].fl.f[STEPS-j]) e2_next[j].fl.m = ex2_mul(e2_reg[j-1].fl.m, RT);
            if (e2_reg[j-1].pk.f[STEPS-j]) e2_next[j].pk.m = ex2_mul(e2_reg[j-1].pk.m, RT);
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) e2_reg[j] <= e2_next[j];
        end
    end

    always_comb begin
        e2_t e;
        e         = e2_reg[STEPS];
        r_next.ac = (e.pos && !e.z_ac) ? ex2_shift(e.ac.m, e.ac.n, OUT_FRAC_BITS) : '0;
        r_next.fl = (e.pos && !e.z_fl) ? ex2_shift(e.fl.m, e.fl.n, OUT_FRAC_BITS) : '0;
        r_next.pk = !ms_reg[1] ? ex2_shift(e.pk.m, e.pk.n, OUT_FRAC_BITS) : '0;
    end

    // add the three terms and saturate
    always_comb begin
        logic [63:0] sum;
        sum      = 64'(r_reg.ac) + 64'(r_reg.fl) + 64'(r_reg.pk);
        out_next = (|sum[63:32]) ? '1 : sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            r_reg   <= r_next;
            out_reg <= out_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted word did not enter the first stage");

    a_back_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the result word is stalled");

endmodule

[bench/msde_checker.sv]
`timescale 1ns / 1ps
module msde_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] freq_sample
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] density_value
    output int          fail_count,
    output int          pending
);
    localparam int     FRQ_FB  = 22;
    localparam int     OUT_FB  = 32;
    localparam int     LFB     = 28;
    localparam longint ONE     = 64'sd1 <<< LFB;
    localparam longint unsigned LOG2E = 64'd387270501;
    localparam longint unsigned CAP   = 64'd1 << 61;
    localparam logic [2:0] ADDR_MATERIAL = 3'd0;

    longint unsigned acoustic_coef [4] = '{100, 120, 80, 200};
    longint unsigned acoustic_cut  [4] = '{400, 350, 1500, 800};
    longint          acoustic_q    [4] = '{15, 15, 12, 18};
    longint unsigned flex_coef     [4] = '{50, 80, 150, 30};
    longint unsigned flex_cut      [4] = '{200, 180, 250, 600};
    longint          flex_pow      [4] = '{3, 4, 2, 6};
    longint unsigned peak_pos      [2] = '{480, 320};
    longint unsigned peak_num      [2] = '{8000, 14400};
    longint unsigned peak_wid      [2] = '{10, 8};

    longint unsigned roots [LFB+1];
    logic [1:0]      material;
    logic [31:0]     density_q [$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_fix(longint unsigned x);
        int              e;
        longint unsigned m;
        longint          fr;
        if (x == 0) return -64 * ONE;
        e = 63;
        fr = 0;
        while (x[e] == 1'b0) e--;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        for (int i = 1; i <= LFB; i++) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                fr = fr | (64'sd1 <<< (LFB - i));
            end
        end
        return longint'(e) * ONE + fr;
    endfunction

    function automatic longint unsigned exp2_fix(longint L, int p);
        longint          n, f, s;
        longint unsigned m;
        m = 64'd1 << 30;
        if (L >= 0) n = L / ONE;
        else        n = -((-L + ONE - 1) / ONE);
        f = L - n * ONE;
        if (n > 64) return CAP;
        if (n < -128) return 0;
        for (int k = 1; k <= LFB; k++)
            if (f[LFB-k]) m = (m * roots[k]) >> 30;
        s = longint'(p) - 30 + n;
        if (s > 30) return CAP;
        if (s >= 0) return m << s;
        if (-s > 62) return 0;
        return m >> (-s);
    endfunction

    function automatic longint unsigned shaped_term(longint lw, longint lg_1e4,
            longint unsigned coef, longint unsigned cut, longint qt, longint pt);
        longint          ul, lt;
        longint unsigned u, y;
        ul = (lw - (log2_fix(cut) - lg_1e4)) * qt / 10;
        if (ul >= 6 * ONE) return 0;
        u = exp2_fix(ul, LFB);
        y = (u * LOG2E) >> LFB;
        lt = log2_fix(coef) - lg_1e4 + lw * pt / 10 - longint'(y);
        return exp2_fix(lt, OUT_FB);
    endfunction

    function automatic logic [31:0] density_at(logic [23:0] raw, logic [1:0] mat);
        longint          w, lg_1e4, lw, w30, pos, dd, lden, lt;
        longint unsigned total, g, d, den;
        int              k;
        w = longint'(signed'(raw));
        total = 0;
        lg_1e4 = log2_fix(10000);
        if (w > 0) begin
            lw = log2_fix(w) - longint'(FRQ_FB) * ONE;
            total += shaped_term(lw, lg_1e4, acoustic_coef[mat], acoustic_cut[mat],
                                 acoustic_q[mat], 10);
            total += shaped_term(lw, lg_1e4, flex_coef[mat], flex_cut[mat], 20,
                                 flex_pow[mat]);
        end
        if (mat < 2) begin
            w30 = w * (64'sd1 <<< (30 - FRQ_FB));
            pos = longint'((peak_pos[mat] * (64'd1 << 30) + 5000) / 10000);
            g = (peak_wid[mat] * (64'd1 << 30) + 5000) / 10000;
            dd = w30 - pos;
            d = (dd < 0) ? longint'(-dd) : longint'(dd);
            k = 0;
            while ((d >> k) >= (64'd1 << 31)) k++;
            d = d >> k;
            g = g >> k;
            den = d * d + g * g;
            lden = log2_fix(den) + longint'(2 * k - 60) * ONE;
            lt = log2_fix(peak_num[mat]) - 3 * lg_1e4 - lden;
            total += exp2_fix(lt, OUT_FB);
        end
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        return total[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= LFB; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    end

    assign pending = density_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            material <= 2'd0;
            density_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MATERIAL)
                material <= pwdata[1:0];
            if (s_tvalid && s_tready)
                density_q.push_back(density_at(s_tdata, material));
            if (m_tvalid && m_tready) begin
                if (density_q.size() == 0) report_mismatch("unexpected word", m_tdata, '0);
                else if (m_tdata !== density_q[0])
                    report_mismatch("density_value", m_tdata, density_q[0]);
                if (density_q.size() != 0) void'(density_q.pop_front());
            end
        end
    end
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    localparam logic [2:0] ADDR_MATERIAL = 3'd0;
    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count, pending;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    int          quiet_cycles = 0;

    always #6 aclk = ~aclk;

    material_spectral_density_eval_top dut (.*);

    msde_checker chk (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .pending
    );

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_material(logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_MATERIAL; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_freq(logic [23:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [23:0] random_freq();
        int sel;
        sel = $urandom_range(9);
        // favor small positive w and the peak region, where the terms live
        if (sel < 3) return 24'($urandom);
        if (sel < 7) return 24'($urandom_range(1, 1 << $urandom_range(0, 22)));
        if (sel < 9) return 24'(($urandom_range(1) ? 201327 : 134218)
                                + $urandom_range(8000) - 4000);
        return -24'($urandom_range(1, 1 << $urandom_range(0, 23)));
    endfunction

    logic [23:0] directed [20] = '{
        24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
        24'h000002, 24'd201327, 24'd134218, 24'd201326, 24'd134219,
        24'h400000, 24'h3FFFFF, 24'hC00000, 24'd41943, 24'd167772,
        24'd629146, 24'd4194, 24'd83886, 24'h555555, 24'hAAAAAA
    };

    initial begin
        int mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 8; ph++) begin
            // upper bits are don't-care; only the low two select the material
            write_material({30'($urandom_range(0, 32'h3FFF_FFFF)), 2'(ph % 4)});
            mode = (ph + ph / 4) % 4;
            send_idle_pct  = (mode == 1) ? 63 : (mode == 3) ? 25 : 0;
            recv_stall_pct = (mode == 2) ? 63 : (mode == 3) ? 25 : 0;
            foreach (directed[i]) send_freq(directed[i]);
            for (int i = 0; i < 225; i++) send_freq(random_freq());
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (pending != 0) @(posedge aclk);
            repeat (110) @(posedge aclk);
        end
        recv_stall_pct = 0;
        repeat (120) @(posedge aclk);
        if (fail_count == 0 && pending == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
